// ----- src/lie_pkg.sv -----
// Package with shared constants for the line input editor.
`default_nettype none

package lie_pkg;

    // Default line capacity, in characters, of each line bank
    localparam int LINE_DEPTH_DEF = 64;

    // Width of the capacity register
    localparam int MAX_LEN_W = 7;

    // Configuration register indexes
    localparam logic REG_ECHO_ENABLE = 1'b0;
    localparam logic REG_MAX_LENGTH  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Control characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_SP = 8'h20;

endpackage

`default_nettype wire

// ----- src/line_input_editor_top.sv -----
// Line input editor: builds command lines from received bytes, with echo and line repeat.
//
// Usage: received bytes enter on the s_ channel (s_valid/s_ready, s_rx_byte). Results leave
// on the m_ channel (m_valid/m_ready) as m_kind (echo byte, line byte, empty-line marker),
// m_data and m_last, which marks the final result caused by one received byte.
// cfg_we/cfg_index/cfg_wdata write echo_enable (index 0) and max_length (index 1); the user must
// write them only while the block is idle, which the block itself does not enforce.
// Sequencing: the block takes one byte at a time; its results are registered in the output
// register. A backspace erase with echo on gives the echo, a space and a backspace. A completed
// line is read out one character at a time, each through a read state and an emit state, set by
// the single line memory and its registered read port; a full line at the default capacity
// holds 63 characters.
// The line and the repeat line share one memory of two banks; ending a line swaps the banks,
// so the line needs no copy.
// Reset clears the line and the repeat line, sets echo on and the capacity to 64.
// When the receiver stalls, the output register holds its item and the sequencer waits; the
// next byte is taken as soon as the current one has handed off its last result.
`default_nettype none

module line_input_editor_top
    import lie_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [MAX_LEN_W-1:0] cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_rx_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_kind,
    output logic [7:0]                m_data,
    output logic                      m_last
);

    localparam int CW        = $clog2(LINE_DEPTH);
    localparam int AW        = CW + 1;
    localparam int MEM_DEPTH = 2 << CW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_SP,
        ST_BS,
        ST_RD,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_ERASE,
        ACT_EMIT
    } act_t;

    state_t                 state_reg;
    act_t                   act_reg;
    logic                   echo_en_reg;
    logic [MAX_LEN_W-1:0]   max_len_reg;
    logic [CW-1:0]          line_cnt_reg;
    logic [CW-1:0]          rep_cnt_reg;
    logic                   line_bank_reg;
    logic                   emit_bank_reg;
    logic [CW-1:0]          emit_cnt_reg;
    logic [CW-1:0]          idx_reg;
    logic [7:0]             echo_byte_reg;
    logic [7:0]             rd_data_reg;
    logic [7:0]             line_mem_reg [MEM_DEPTH];
    logic                   m_valid_reg;
    logic [1:0]             m_kind_reg;
    logic [7:0]             m_data_reg;
    logic                   m_last_reg;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic                   is_cr_empty;
    logic                   is_erase;
    logic                   is_end;
    logic                   wr_en;
    logic [MAX_LEN_W-1:0]   cap;
    logic [MAX_LEN_W-1:0]   limit;
    logic [MAX_LEN_W-1:0]   new_cnt;
    logic                   at_limit;
    logic                   emit_last;
    state_t                 emit_state;
    state_t                 after_echo;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // The output register takes a new item in this cycle
    assign out_load = out_free &&
                      (state_reg inside {ST_ECHO, ST_SP, ST_BS, ST_EMIT, ST_EMPTY});

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

    // Classify the incoming byte
    assign is_cr_empty = (s_rx_byte == CH_CR) && (line_cnt_reg == '0);
    assign is_erase    = (s_rx_byte == CH_BS) && (line_cnt_reg != '0);
    assign is_end      = (s_rx_byte == CH_LF) || (s_rx_byte == CH_CR);
    assign wr_en       = accept && !is_cr_empty && !is_erase && !is_end;

    // Clamp the capacity and find the character limit
    always_comb begin
        if (max_len_reg < MAX_LEN_W'(2)) begin
            cap = MAX_LEN_W'(2);
        end else if (max_len_reg > MAX_LEN_W'(LINE_DEPTH)) begin
            cap = MAX_LEN_W'(LINE_DEPTH);
        end else begin
            cap = max_len_reg;
        end
    end

    assign limit    = cap - MAX_LEN_W'(1);
    assign new_cnt  = {{(MAX_LEN_W-CW){1'b0}}, line_cnt_reg} + MAX_LEN_W'(1);
    assign at_limit = (new_cnt >= limit);

    assign emit_last  = (idx_reg == emit_cnt_reg - CW'(1));
    assign emit_state = (emit_cnt_reg == '0) ? ST_EMPTY : ST_RD;

    // Pick the step that follows the echo
    always_comb begin
        case (act_reg)
            ACT_ERASE: after_echo = ST_SP;
            ACT_EMIT:  after_echo = emit_state;
            default:   after_echo = ST_IDLE;
        endcase
    end

    // Line memory: two banks, one for the line being edited, one for the repeat line
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem_reg[{line_bank_reg, line_cnt_reg}] <= s_rx_byte;
        end
        rd_data_reg <= line_mem_reg[AW'({emit_bank_reg, idx_reg})];
    end

    // Sequencer, line state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            act_reg       <= ACT_NONE;
            echo_en_reg   <= 1'b1;
            max_len_reg   <= MAX_LEN_W'(64);
            line_cnt_reg  <= '0;
            rep_cnt_reg   <= '0;
            line_bank_reg <= 1'b0;
            emit_bank_reg <= 1'b0;
            emit_cnt_reg  <= '0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Release the output item once taken
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end

            // Write configuration
            if (cfg_we) begin
                case (cfg_index)
                    REG_ECHO_ENABLE: echo_en_reg <= cfg_wdata[0];
                    REG_MAX_LENGTH:  max_len_reg <= cfg_wdata;
                    default:         ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        echo_byte_reg <= s_rx_byte;
                        idx_reg       <= '0;
                        if (is_cr_empty) begin
                            // Replay the repeat line
                            act_reg       <= ACT_EMIT;
                            emit_bank_reg <= !line_bank_reg;
                            emit_cnt_reg  <= rep_cnt_reg;
                        end else if (is_erase) begin
                            line_cnt_reg <= line_cnt_reg - CW'(1);
                            act_reg      <= echo_en_reg ? ACT_ERASE : ACT_NONE;
                        end else if (is_end) begin
                            // End the line: it becomes the repeat line
                            act_reg       <= ACT_EMIT;
                            emit_bank_reg <= line_bank_reg;
                            emit_cnt_reg  <= line_cnt_reg;
                            rep_cnt_reg   <= line_cnt_reg;
                            line_bank_reg <= !line_bank_reg;
                            line_cnt_reg  <= '0;
                        end else if (at_limit) begin
                            // Line full: emit it, keep the repeat line
                            act_reg       <= ACT_EMIT;
                            emit_bank_reg <= line_bank_reg;
                            emit_cnt_reg  <= new_cnt[CW-1:0];
                            line_cnt_reg  <= '0;
                        end else begin
                            act_reg      <= ACT_NONE;
                            line_cnt_reg <= new_cnt[CW-1:0];
                        end

                        if (echo_en_reg) begin
                            state_reg <= ST_ECHO;
                        end else if (is_cr_empty) begin
                            state_reg <= (rep_cnt_reg == '0) ? ST_EMPTY : ST_RD;
                        end else if (is_end) begin
                            state_reg <= (line_cnt_reg == '0) ? ST_EMPTY : ST_RD;
                        end else if (!is_erase && at_limit) begin
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_ECHO: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KIND_ECHO;
                        m_data_reg  <= echo_byte_reg;
                        m_last_reg  <= (act_reg == ACT_NONE);
                        state_reg   <= after_echo;
                    end
                end
                ST_SP: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KIND_ECHO;
                        m_data_reg  <= CH_SP;
                        m_last_reg  <= 1'b0;
                        state_reg   <= ST_BS;
                    end
                end
                ST_BS: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KIND_ECHO;
                        m_data_reg  <= CH_BS;
                        m_last_reg  <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_RD: begin
                    // Wait for the registered read data
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KIND_LINE;
                        m_data_reg  <= rd_data_reg;
                        m_last_reg  <= emit_last;
                        if (emit_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_EMPTY: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KIND_EMPTY;
                        m_data_reg  <= 8'h00;
                        m_last_reg  <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb_line_input_editor_top.sv -----
// Self-checking testbench for the line input editor: directed and random bytes, scoreboard.
`timescale 1ns / 100ps

module tb_line_input_editor_top;
    import lie_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_RES       = 66;
    localparam int RAND_PHASES   = 4;
    localparam int PHASE_ITEMS   = 12;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } edit_out_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = REG_ECHO_ENABLE;
    logic [MAX_LEN_W-1:0] cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [1:0]           m_kind;
    logic [7:0]           m_data;
    logic                 m_last;

    // Mirror of the editor state and registers
    logic [7:0]           line_chars [0:LINE_DEPTH_DEF-1];
    logic [5:0]           line_len;
    logic [7:0]           recall_chars [0:LINE_DEPTH_DEF-1];
    logic [5:0]           recall_len;
    logic                 echo_on;
    logic [MAX_LEN_W-1:0] cap_reg;

    edit_out_t            out_items_due [$];
    logic [7:0]           rx_bytes_pending [$];
    edit_out_t            got_item;

    int n_queued   = 0;
    int n_offered  = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_echo     = 0;
    int n_line     = 0;
    int n_empty    = 0;
    int n_bad      = 0;
    int n_settings = 1;
    int idle_odds  = 0;
    int hold_reqs  = 0;
    int hold_seen  = 0;
    int stall_left = 0;
    int gap_left   = 0;

    line_input_editor_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_data    (m_data),
        .m_last    (m_last)
    );

    always begin
        aclk = 1'b1;
        #(CLK_PERIOD / 2);
        aclk = 1'b0;
        #(CLK_PERIOD / 2);
    end

    // Predict the results of one received byte and queue them in order
    task automatic edit_byte(input logic [7:0] c);
        edit_out_t  pend [0:MAX_RES-1];
        int         n;
        int         k;
        int         cnt;
        logic       emit;
        logic       from_recall;
        logic       save;
        logic       wipe;
        logic [6:0] lim;
        n           = 0;
        emit        = 1'b0;
        from_recall = 1'b0;
        save        = 1'b0;
        wipe        = 1'b0;
        if (cap_reg < 7'd2) begin
            lim = 7'd1;
        end else if (cap_reg > 7'(LINE_DEPTH_DEF)) begin
            lim = 7'(LINE_DEPTH_DEF - 1);
        end else begin
            lim = cap_reg - 7'd1;
        end

        if (echo_on) begin
            pend[n] = {KIND_ECHO, c, 1'b0};
            n++;
        end

        if (c == CH_CR && line_len == 0) begin
            emit        = 1'b1;
            from_recall = 1'b1;
        end else if (c == CH_BS && line_len > 0) begin
            // erase the last character on the terminal
            if (echo_on) begin
                pend[n] = {KIND_ECHO, CH_SP, 1'b0};
                n++;
                pend[n] = {KIND_ECHO, CH_BS, 1'b0};
                n++;
            end
            line_len = line_len - 6'd1;
        end else if (c == CH_LF || c == CH_CR) begin
            emit = 1'b1;
            save = 1'b1;
        end else begin
            line_chars[line_len] = c;
            line_len = line_len + 6'd1;
            if ({1'b0, line_len} >= lim) begin
                emit = 1'b1;
                wipe = 1'b1;
            end
        end

        // walk the completed line out, or mark it empty
        if (emit) begin
            cnt = from_recall ? recall_len : line_len;
            if (cnt == 0) begin
                pend[n] = {KIND_EMPTY, 8'h00, 1'b0};
                n++;
            end
            for (k = 0; k < cnt && n < MAX_RES; k++) begin
                pend[n] = {KIND_LINE, from_recall ? recall_chars[k] : line_chars[k], 1'b0};
                n++;
            end
        end
        if (save) begin
            for (k = 0; k < line_len; k++) begin
                recall_chars[k] = line_chars[k];
            end
            recall_len = line_len;
        end
        if (save || wipe) begin
            line_len = '0;
        end

        for (k = 0; k < n; k++) begin
            if (k == n - 1) begin
                pend[k].last = 1'b1;
            end
            out_items_due.push_back(pend[k]);
        end
    endtask

    // Offer queued bytes, with random gaps between items
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && n_accepted != n_offered) begin
            // hold the item until it is taken
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (rx_bytes_pending.size() > 0 && idle_odds > 0
                     && $urandom_range(0, 99) < idle_odds) begin
            gap_left = $urandom_range(0, 14);
            s_valid <= 1'b0;
        end else if (rx_bytes_pending.size() > 0) begin
            s_rx_byte <= rx_bytes_pending.pop_front();
            s_valid   <= 1'b1;
            n_offered++;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Accept results, with random stalls and an occasional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen  = hold_reqs;
            stall_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
            stall_left = $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Predict on each accepted byte, compare each accepted result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                edit_byte(s_rx_byte);
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                n_results++;
                case (m_kind)
                    KIND_ECHO:  n_echo++;
                    KIND_LINE:  n_line++;
                    KIND_EMPTY: n_empty++;
                    default: ;
                endcase
                if (out_items_due.size() == 0) begin
                    n_bad++;
                    $display("%0t: unexpected result kind %0d data %02h last %0d", $time,
                             m_kind, m_data, m_last);
                end else begin
                    got_item = out_items_due.pop_front();
                    if (m_kind !== got_item.kind || m_data !== got_item.data
                        || m_last !== got_item.last) begin
                        n_bad++;
                        $display("%0t: expected kind %0d data %02h last %0d,", $time,
                                 got_item.kind, got_item.data, got_item.last,
                                 " got kind %0d data %02h last %0d",
                                 m_kind, m_data, m_last);
                    end
                end
            end
        end
    end

    task automatic send(input logic [7:0] c);
        rx_bytes_pending.push_back(c);
        n_queued++;
    endtask

    // Wait until every byte is taken and every result has come, then let the block go quiet
    task automatic drain();
        while (rx_bytes_pending.size() != 0 || n_accepted != n_queued
               || out_items_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [MAX_LEN_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_ECHO_ENABLE) begin
            echo_on = val[0];
        end else begin
            cap_reg = val;
        end
    endtask

    task automatic set_mode(input logic echo, input logic [MAX_LEN_W-1:0] cap);
        write_reg(REG_ECHO_ENABLE, {6'd0, echo});
        write_reg(REG_MAX_LENGTH, cap);
        n_settings++;
    endtask

    // Queue one line of random content, mostly printable, then a random ending
    task automatic add_line(input int len);
        int         k;
        logic [7:0] c;
        for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0:       c = CH_BS;
                1, 2:    c = 8'($urandom_range(0, 255));
                default: c = 8'($urandom_range(8'h21, 8'h7E));
            endcase
            send(c);
        end
        case ($urandom_range(0, 5))
            0: send(CH_LF);
            1, 2: send(CH_CR);
            3: begin
                send(CH_CR);
                send(CH_CR);
            end
            4: ;
            default: begin
                send(8'($urandom_range(0, 255)));
                send(CH_CR);
            end
        endcase
    endtask

    task automatic random_phase(input int count, input logic long_line);
        int start;
        int len;
        start = n_queued;
        if (long_line) begin
            add_line($urandom_range(63, 70));
        end
        while (n_queued - start < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send(8'($urandom_range(0, 255)));
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
                                                  : $urandom_range(0, 8);
                add_line(len);
            end
        end
    endtask

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("timeout at %0t", $time);
        $display("tb_line_input_editor_top NOT OK");
        $finish;
    end

    initial begin
        int               ph;
        int               k;
        logic             echo;
        logic [MAX_LEN_W-1:0] cap;
        line_len   = '0;
        recall_len = '0;
        echo_on    = 1'b1;
        cap_reg    = 7'd64;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty-line cases, backspace on an empty line, zero byte, erase, replay
        send(CH_CR);
        send(CH_LF);
        send(CH_BS);
        send(8'h00);
        send(8'hFF);
        send(8'h71);
        send(CH_BS);
        send(CH_CR);
        send(CH_CR);
        send(CH_LF);
        send(CH_CR);
        drain();

        // Capacity below range, echo off
        set_mode(1'b0, 7'd0);
        send(8'h41);
        send(CH_CR);
        send(CH_BS);
        send(CH_LF);
        drain();

        // Capacity above range; a byte with no result
        set_mode(1'b0, 7'd127);
        send(8'h6B);
        send(CH_CR);
        drain();

        set_mode(1'b1, 7'd1);
        send(8'h7A);
        drain();

        // Lower the capacity under a partly typed line
        set_mode(1'b1, 7'd64);
        for (k = 0; k < 8; k++) begin
            send(8'($urandom_range(8'h30, 8'h7A)));
        end
        drain();
        write_reg(REG_MAX_LENGTH, 7'd4);
        send(8'h2E);
        drain();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            echo = ph[0] ^ 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                0:       cap = 7'($urandom_range(0, 127));
                1:       cap = 7'd2;
                2:       cap = 7'd64;
                3:       cap = 7'd127;
                default: cap = 7'($urandom_range(2, 8));
            endcase
            if (ph == 1) begin
                cap = 7'd64;
            end
            set_mode(echo, cap);
            if (ph == RAND_PHASES - 1) begin
                idle_odds = 0;
            end else begin
                idle_odds = ($urandom_range(0, 2) == 0) ? 0 : 25;
            end
            // hold the receiver off while a long line is offered
            if (ph == 1) begin
                hold_reqs++;
            end
            random_phase(PHASE_ITEMS, ph == 1);
            drain();
        end

        $display("ran %0d bytes under %0d register settings", n_accepted, n_settings);
        $display("checked %0d results: %0d echo, %0d line, %0d empty-line",
                 n_results, n_echo, n_line, n_empty);
        if (n_bad == 0) begin
            $display("tb_line_input_editor_top OK");
        end else begin
            $display("tb_line_input_editor_top NOT OK");
        end
        $finish;
    end

endmodule
